>>> rtl/core/qte_pkg.sv
// qte_pkg: widths, constants and the arctangent table shared by the
// quaternion to Euler angle block. No dependencies.
`timescale 1ns / 1ps

package qte_pkg;

  localparam int QW       = 32;  // input component width, Q30
  localparam int PW       = 35;  // Q30 product after the shift
  localparam int VW       = 46;  // atan2 operand width
  localparam int AW       = 35;  // angle width, Q30 radians
  localparam int RW       = 61;  // square root radicand width
  localparam int MAX_STEPS = 30;
  localparam int NORM_BIT = 40;  // operands are scaled up to 2^40
  localparam int SQRT_STAGES = 31;

  localparam logic signed [VW-1:0] Q30_ONE = VW'(64'sd1073741824);
  localparam logic signed [AW-1:0] HALF_PI = AW'(64'sd1686629713);
  localparam logic [12:0]          CDEG_SCALE = 13'd5730;

  typedef struct packed {
    logic signed [QW-1:0] w;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } quat_item_t;

  function automatic int steps_used(input int steps);
    return (steps > MAX_STEPS) ? MAX_STEPS : steps;
  endfunction

  // round(atan(2^-i) * 2^30)
  function automatic logic signed [AW-1:0] atan_entry(input int i);
    logic signed [AW-1:0] r;
    unique case (i)
      0:  r = AW'(64'sd843314857);
      1:  r = AW'(64'sd497837829);
      2:  r = AW'(64'sd263043837);
      3:  r = AW'(64'sd133525159);
      4:  r = AW'(64'sd67021687);
      5:  r = AW'(64'sd33543516);
      6:  r = AW'(64'sd16775851);
      7:  r = AW'(64'sd8388437);
      8:  r = AW'(64'sd4194283);
      9:  r = AW'(64'sd2097149);
      default: r = AW'(64'sd1) <<< (30 - i);
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/qte_front.sv
// qte_front: input register of the block; drops items with no quaternion.
// Depends on qte_pkg.
`timescale 1ns / 1ps

module qte_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       quat_valid,
  output logic                       quat_stall,
  input  logic signed [31:0]         quat_w,
  input  logic signed [31:0]         quat_x,
  input  logic signed [31:0]         quat_y,
  input  logic signed [31:0]         quat_z,
  input  logic                       quat_present,
  input  logic                       queue_full,
  output logic                       push,
  output qte_pkg::quat_item_t        push_item
);
  import qte_pkg::*;

  logic       held;
  logic       held_next;
  quat_item_t item;
  logic       accept;

  assign quat_stall = held && queue_full;
  assign accept     = quat_valid && !quat_stall;
  assign push       = held && !queue_full;
  assign push_item  = item;

  always_comb begin
    held_next = held;
    if (accept) begin
      held_next = quat_present;
    end else if (push) begin
      held_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= '{w: quat_w, x: quat_x, y: quat_y, z: quat_z};
    end
  end

endmodule

>>> rtl/core/qte_queue.sv
// qte_queue: short register queue between the front and the back part.
// Depends on qte_pkg.
`timescale 1ns / 1ps

module qte_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  qte_pkg::quat_item_t push_item,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output qte_pkg::quat_item_t head_item
);
  import qte_pkg::*;

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);

  quat_item_t      slots [DEPTH];
  logic [PTRW-1:0] wp;
  logic [PTRW-1:0] rp;
  logic [CW-1:0]   cnt;
  logic            do_push;
  logic            do_pop;

  assign full       = (cnt == CW'(DEPTH));
  assign head_valid = (cnt != '0);
  assign head_item  = slots[rp];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PTRW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == PTRW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH)) else $error("queue count beyond depth");
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid) else $error("pop from empty queue");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> cnt == $past(cnt) + 1'b1)
    else $error("queue count did not follow push");

endmodule

>>> rtl/core/qte_atan2.sv
// qte_atan2: pipelined atan2 - operand scaling, quadrant fold, CORDIC.
// Depends on qte_pkg.
`timescale 1ns / 1ps

module qte_atan2 #(
  parameter int STEPS = 16
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [qte_pkg::VW-1:0]   y_in,
  input  logic signed [qte_pkg::VW-1:0]   x_in,
  output logic signed [qte_pkg::AW-1:0]   angle
);
  import qte_pkg::*;

  localparam int NS    = steps_used(STEPS);
  localparam int NNORM = 7;

  // scaling stages: shifts of 32,16,8,4,2,1, then the final doubling
  logic signed [VW-1:0] nx [NNORM+1];
  logic signed [VW-1:0] ny [NNORM+1];
  logic                 nzero [NNORM+1];

  assign nx[0]    = x_in;
  assign ny[0]    = y_in;
  assign nzero[0] = (x_in == '0) && (y_in == '0);

  for (genvar j = 0; j < NNORM; j++) begin : g_norm
    localparam int SH = (j < NNORM - 1) ? (32 >> j) : 1;
    localparam int LO = (j < NNORM - 1) ? (NORM_BIT - SH) : NORM_BIT;
    logic [VW-1:0] mx;
    logic [VW-1:0] my;
    logic          below;
    assign mx    = nx[j][VW-1] ? VW'(-nx[j]) : VW'(nx[j]);
    assign my    = ny[j][VW-1] ? VW'(-ny[j]) : VW'(ny[j]);
    assign below = ((mx | my) >> LO) == '0;
    always_ff @(posedge clk) begin
      if (en) begin
        nx[j+1]    <= below ? (nx[j] <<< SH) : nx[j];
        ny[j+1]    <= below ? (ny[j] <<< SH) : ny[j];
        nzero[j+1] <= nzero[j];
      end
    end
  end

  logic signed [VW-1:0] cx [NS+1];
  logic signed [VW-1:0] cy [NS+1];
  logic signed [AW-1:0] cz [NS+1];
  logic                 czero [NS+1];

  // fold the left half plane onto the right
  always_ff @(posedge clk) begin
    if (en) begin
      czero[0] <= nzero[NNORM];
      if (nx[NNORM][VW-1]) begin
        if (!ny[NNORM][VW-1]) begin
          cx[0] <= ny[NNORM];
          cy[0] <= -nx[NNORM];
          cz[0] <= HALF_PI;
        end else begin
          cx[0] <= -ny[NNORM];
          cy[0] <= nx[NNORM];
          cz[0] <= -HALF_PI;
        end
      end else begin
        cx[0] <= nx[NNORM];
        cy[0] <= ny[NNORM];
        cz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    logic pos;
    assign pos = !cy[i][VW-1] && (cy[i] != '0);
    always_ff @(posedge clk) begin
      if (en) begin
        czero[i+1] <= czero[i];
        if (pos) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + atan_entry(i);
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - atan_entry(i);
        end
      end
    end
  end

  assign angle = czero[NS] ? '0 : cz[NS];

endmodule

>>> rtl/core/qte_back.sv
// qte_back: products, sums, pitch square root, three atan2 pipelines and
// conversion to hundredths of a degree. Depends on qte_pkg, qte_atan2.
`timescale 1ns / 1ps

module qte_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  qte_pkg::quat_item_t head_item,
  output logic                pop,
  output logic                euler_valid,
  input  logic                euler_stall,
  output logic signed [14:0]  pitch_cdeg,
  output logic signed [15:0]  roll_cdeg,
  output logic signed [15:0]  yaw_cdeg
);
  import qte_pkg::*;

  localparam int LAT_A = 8 + steps_used(CORDIC_STEPS);
  localparam int NV    = 3 + SQRT_STAGES + LAT_A + 1;

  logic          en;
  logic [NV-1:0] vld;

  assign en          = !euler_valid || !euler_stall;
  assign pop         = en && head_valid;
  assign euler_valid = vld[NV-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NV-2:0], head_valid};
    end
  end

  // products, Q30 with floor
  logic signed [PW-1:0] p_wy, p_xz, p_yz, p_wx, p_xx, p_yy, p_xy, p_wz, p_ww, p_zz;

  function automatic logic signed [PW-1:0] mulq(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] t;
    t = a * b;
    return PW'(t >>> 30);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      p_wy <= mulq(head_item.w, head_item.y);
      p_xz <= mulq(head_item.x, head_item.z);
      p_yz <= mulq(head_item.y, head_item.z);
      p_wx <= mulq(head_item.w, head_item.x);
      p_xx <= mulq(head_item.x, head_item.x);
      p_yy <= mulq(head_item.y, head_item.y);
      p_xy <= mulq(head_item.x, head_item.y);
      p_wz <= mulq(head_item.w, head_item.z);
      p_ww <= mulq(head_item.w, head_item.w);
      p_zz <= mulq(head_item.z, head_item.z);
    end
  end

  // sums
  logic signed [QW-1:0] s2;
  logic signed [VW-1:0] rn2, rd2, yn2, yd2;
  logic signed [VW-1:0] s_full;

  assign s_full = (VW'(p_wy) - VW'(p_xz)) <<< 1;

  always_ff @(posedge clk) begin
    if (en) begin
      if (s_full > Q30_ONE) begin
        s2 <= QW'(Q30_ONE);
      end else if (s_full < -Q30_ONE) begin
        s2 <= QW'(-Q30_ONE);
      end else begin
        s2 <= QW'(s_full);
      end
      rn2 <= (VW'(p_yz) + VW'(p_wx)) <<< 1;
      rd2 <= Q30_ONE - ((VW'(p_xx) + VW'(p_yy)) <<< 1);
      yn2 <= (VW'(p_xy) + VW'(p_wz)) <<< 1;
      yd2 <= VW'(p_ww) + VW'(p_xx) - VW'(p_yy) - VW'(p_zz);
    end
  end

  // radicand 1 - s^2, then one root bit per stage
  logic [RW-1:0]        rem  [SQRT_STAGES+1];
  logic [RW-1:0]        root [SQRT_STAGES+1];
  logic signed [QW-1:0] ds   [SQRT_STAGES+1];
  logic signed [VW-1:0] drn  [SQRT_STAGES+1];
  logic signed [VW-1:0] drd  [SQRT_STAGES+1];
  logic signed [VW-1:0] dyn  [SQRT_STAGES+1];
  logic signed [VW-1:0] dyd  [SQRT_STAGES+1];
  logic signed [2*QW-1:0] sq;

  assign sq = s2 * s2;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= RW'(64'd1152921504606846976 - 64'(sq));
      root[0] <= '0;
      ds[0]   <= s2;
      drn[0]  <= rn2;
      drd[0]  <= rd2;
      dyn[0]  <= yn2;
      dyd[0]  <= yd2;
    end
  end

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    localparam logic [RW:0] BIT = (RW+1)'(1) << (60 - 2 * k);
    logic [RW:0] trial;
    assign trial = {1'b0, root[k]} + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem[k]} >= trial) begin
          rem[k+1]  <= rem[k] - trial[RW-1:0];
          root[k+1] <= (root[k] >> 1) + BIT[RW-1:0];
        end else begin
          rem[k+1]  <= rem[k];
          root[k+1] <= root[k] >> 1;
        end
        ds[k+1]  <= ds[k];
        drn[k+1] <= drn[k];
        drd[k+1] <= drd[k];
        dyn[k+1] <= dyn[k];
        dyd[k+1] <= dyd[k];
      end
    end
  end

  logic signed [VW-1:0] pitch_y, pitch_x;
  logic signed [AW-1:0] a_pitch, a_roll, a_yaw;

  assign pitch_y = VW'(ds[SQRT_STAGES]);
  assign pitch_x = $signed({1'b0, root[SQRT_STAGES][VW-2:0]});

  qte_atan2 #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .en(en), .y_in(pitch_y), .x_in(pitch_x), .angle(a_pitch)
  );
  qte_atan2 #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .en(en), .y_in(drn[SQRT_STAGES]), .x_in(drd[SQRT_STAGES]),
    .angle(a_roll)
  );
  qte_atan2 #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .en(en), .y_in(dyn[SQRT_STAGES]), .x_in(dyd[SQRT_STAGES]),
    .angle(a_yaw)
  );

  // sign(a) * floor(|a| * 5730 / 2^30)
  function automatic logic signed [18:0] to_cdeg(input logic signed [AW-1:0] a);
    logic [AW-1:0] m;
    logic [47:0]   pm;
    logic signed [18:0] v;
    m  = a[AW-1] ? AW'(-a) : AW'(a);
    pm = 48'(m) * 48'(CDEG_SCALE);
    v  = $signed({1'b0, pm[47:30]});
    return a[AW-1] ? -v : v;
  endfunction

  logic signed [18:0] c_pitch, c_roll, c_yaw;
  assign c_pitch = to_cdeg(a_pitch);
  assign c_roll  = to_cdeg(a_roll);
  assign c_yaw   = to_cdeg(a_yaw);

  always_ff @(posedge clk) begin
    if (en) begin
      pitch_cdeg <= c_pitch[14:0];
      roll_cdeg  <= c_roll[15:0];
      yaw_cdeg   <= c_yaw[15:0];
    end
  end

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    euler_valid |-> (pitch_cdeg <= 15'sd9001 && pitch_cdeg >= -15'sd9001))
    else $error("pitch out of range");
  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    euler_valid |-> (roll_cdeg <= 16'sd18002 && roll_cdeg >= -16'sd18002))
    else $error("roll out of range");
  a_pop_needs_room: assert property (@(posedge clk) disable iff (rst)
    pop |-> !(euler_valid && euler_stall)) else $error("pop while stalled");

endmodule

>>> rtl/core/quaternion_to_euler_angles_top.sv
// quaternion_to_euler_angles_top: top level, Z-Y-X Euler angles from a Q30
// quaternion. Depends on qte_pkg, qte_front, qte_queue, qte_back.
`timescale 1ns / 1ps

// Usage
//   Input channel quat_*: an item is taken on a rising edge with quat_valid
//   high and quat_stall low. Items with quat_present low are dropped in the
//   front register and give no result.
//   Output channel euler_*: pitch, roll and yaw in 0.01 degree, taken on an
//   edge with euler_valid high and euler_stall low.
//   Throughput: one item per cycle while the receiver keeps up.
//   Path from acceptance to euler_valid: front register, queue, product,
//   sum and radicand stages, 31 root stages for the pitch cosine, 8
//   scaling/fold stages and one stage per CORDIC step, output register.
//   Stall: euler_stall with euler_valid high freezes the whole back pipeline;
//   the front keeps taking items until the QUEUE_DEPTH-entry queue and its
//   own register are full, then raises quat_stall.
//   Reset (rst, synchronous): all valid flags and the queue are emptied;
//   no result appears until a new item arrives.
module quaternion_to_euler_angles_top #(
  parameter int CORDIC_STEPS = 16,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               quat_valid,
  output logic               quat_stall,
  input  logic signed [31:0] quat_w,
  input  logic signed [31:0] quat_x,
  input  logic signed [31:0] quat_y,
  input  logic signed [31:0] quat_z,
  input  logic               quat_present,
  output logic               euler_valid,
  input  logic               euler_stall,
  output logic signed [14:0] pitch_cdeg,
  output logic signed [15:0] roll_cdeg,
  output logic signed [15:0] yaw_cdeg
);
  import qte_pkg::*;

  logic       push;
  quat_item_t push_item;
  logic       full;
  logic       pop;
  logic       head_valid;
  quat_item_t head_item;

  // front: accept and drop absent items
  qte_front u_front (
    .clk(clk), .rst(rst),
    .quat_valid(quat_valid), .quat_stall(quat_stall),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .quat_present(quat_present),
    .queue_full(full), .push(push), .push_item(push_item)
  );

  // queue decouples the two sides
  qte_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_item(push_item), .full(full),
    .pop(pop), .head_valid(head_valid), .head_item(head_item)
  );

  // back: arithmetic pipeline ending in the output register
  qte_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk(clk), .rst(rst),
    .head_valid(head_valid), .head_item(head_item), .pop(pop),
    .euler_valid(euler_valid), .euler_stall(euler_stall),
    .pitch_cdeg(pitch_cdeg), .roll_cdeg(roll_cdeg), .yaw_cdeg(yaw_cdeg)
  );

endmodule
